### src/cbad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and constants for the console bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int WORK_RAM_DEPTH_DEF   = 32768;
  localparam int BACKUP_RAM_DEPTH_DEF = 8192;

  localparam int WRAM_SPAN = 32768;
  localparam int BRAM_SPAN = 8192;

  localparam logic [7:0]  PAGE_WRAM_LO = 8'hF8;
  localparam logic [7:0]  PAGE_WRAM_HI = 8'hFB;
  localparam logic [7:0]  PAGE_BRAM    = 8'hF7;
  localparam logic [7:0]  PAGE_IO      = 8'hFF;
  localparam logic [20:0] ROM_TOP      = 21'h0FFFFF;

  localparam logic [12:0] IO_VDC_HI   = 13'h0003;
  localparam logic [12:0] IO_VCE_LO   = 13'h0400;
  localparam logic [12:0] IO_VCE_HI   = 13'h0405;
  localparam logic [12:0] IO_PSG_LO   = 13'h0800;
  localparam logic [12:0] IO_PSG_HI   = 13'h0809;
  localparam logic [12:0] IO_TIMER_0  = 13'h0C00;
  localparam logic [12:0] IO_TIMER_1  = 13'h0C01;
  localparam logic [12:0] IO_PAD      = 13'h1000;
  localparam logic [12:0] IO_IRQ_0    = 13'h1402;
  localparam logic [12:0] IO_IRQ_1    = 13'h1403;
  localparam logic [12:0] IO_BRAM_CTL = 13'h1807;

  localparam logic [7:0] FILL_BUS = 8'hFF;
  localparam logic [7:0] PAD_TGX  = 8'h40;

  typedef enum logic [3:0] {
    TGT_NONE  = 4'd0,
    TGT_ROM   = 4'd1,
    TGT_WRAM  = 4'd2,
    TGT_BRAM  = 4'd3,
    TGT_VDC   = 4'd4,
    TGT_VCE   = 4'd5,
    TGT_PSG   = 4'd6,
    TGT_TIMER = 4'd7,
    TGT_PAD   = 4'd8,
    TGT_IRQ   = 4'd9
  } target_t;

  typedef enum logic [1:0] {
    SRC_FIXED = 2'd0,
    SRC_WRAM  = 2'd1,
    SRC_BRAM  = 2'd2
  } rd_src_t;

  typedef struct packed {
    target_t     tgt;
    logic [19:0] offset;
    logic        strobe;
    logic [7:0]  fill;
    rd_src_t     src;
    logic        wram_hit;
    logic        bram_hit;
    logic        pad_wr;
    logic        bflag_set;
  } dec_t;

  typedef struct packed {
    logic busy;
    logic wram_we;
    logic bram_we;
  } clr_t;

endpackage

### src/cbad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### src/cbad_clear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_clear
// Post-reset sweep that zeroes both RAMs, one entry per cycle.
// ----------------------------------------------------------------------------
module cbad_clear #(
  parameter int WORK_RAM_DEPTH   = cbad_pkg::WORK_RAM_DEPTH_DEF,
  parameter int BACKUP_RAM_DEPTH = cbad_pkg::BACKUP_RAM_DEPTH_DEF,
  localparam int MAX_DEPTH = (WORK_RAM_DEPTH > BACKUP_RAM_DEPTH) ?
                             WORK_RAM_DEPTH : BACKUP_RAM_DEPTH,
  localparam int CA        = $clog2(MAX_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  output cbad_pkg::clr_t    clr,
  output logic [CA-1:0]     clr_idx
);

  logic          busy_r, busy_nxt;
  logic [CA-1:0] cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CA'(MAX_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign clr.busy    = busy_r;
  assign clr.wram_we = busy_r && ({1'b0, cnt_r} < (CA+1)'(WORK_RAM_DEPTH));
  assign clr.bram_we = busy_r && ({1'b0, cnt_r} < (CA+1)'(BACKUP_RAM_DEPTH));
  assign clr_idx     = cnt_r;

endmodule

### src/cbad_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_decode
// Page and I/O window decode for one bus word, RAM index folding.
// ----------------------------------------------------------------------------
module cbad_decode #(
  parameter int WORK_RAM_DEPTH   = cbad_pkg::WORK_RAM_DEPTH_DEF,
  parameter int BACKUP_RAM_DEPTH = cbad_pkg::BACKUP_RAM_DEPTH_DEF,
  localparam int WA = $clog2(WORK_RAM_DEPTH),
  localparam int BA = $clog2(BACKUP_RAM_DEPTH)
) (
  input  logic             command,
  input  logic [20:0]      bus_address,
  input  logic [7:0]       pad_buttons,
  input  logic             nibble_sel,
  input  logic             tgx_mode,
  output cbad_pkg::dec_t   dec,
  output logic [WA-1:0]    wram_idx,
  output logic [BA-1:0]    bram_idx
);

  localparam int WSTEPS = (cbad_pkg::WRAM_SPAN - 1) / WORK_RAM_DEPTH;
  localparam int BSTEPS = (cbad_pkg::BRAM_SPAN - 1) / BACKUP_RAM_DEPTH;
  localparam logic [15:0] WD16 = 16'(WORK_RAM_DEPTH);
  localparam logic [13:0] BD14 = 14'(BACKUP_RAM_DEPTH);

  logic [7:0]  page;
  logic [12:0] io;
  logic [15:0] wv;
  logic [13:0] bv;
  logic [7:0]  pad_inv;
  logic [7:0]  pad_val;

  assign page    = bus_address[20:13];
  assign io      = bus_address[12:0];
  assign pad_inv = ~pad_buttons;

  always_comb begin
    wv = {1'b0, bus_address[14:0]};
    for (int i = 0; i < WSTEPS; i++) begin
      if (wv >= WD16) wv = wv - WD16;
    end
    bv = {1'b0, bus_address[12:0]};
    for (int i = 0; i < BSTEPS; i++) begin
      if (bv >= BD14) bv = bv - BD14;
    end
  end

  assign wram_idx = wv[WA-1:0];
  assign bram_idx = bv[BA-1:0];

  always_comb begin
    pad_val = {4'h0, nibble_sel ? pad_inv[7:4] : pad_inv[3:0]};
    if (tgx_mode) pad_val = pad_val | cbad_pkg::PAD_TGX;
  end

  always_comb begin
    dec = '{tgt: cbad_pkg::TGT_NONE, offset: '0, strobe: 1'b0, fill: '0,
            src: cbad_pkg::SRC_FIXED, wram_hit: 1'b0, bram_hit: 1'b0,
            pad_wr: 1'b0, bflag_set: 1'b0};
    priority if (page >= cbad_pkg::PAGE_WRAM_LO && page <= cbad_pkg::PAGE_WRAM_HI) begin
      dec.tgt      = cbad_pkg::TGT_WRAM;
      dec.offset   = 20'(wram_idx);
      dec.wram_hit = 1'b1;
      dec.src      = command ? cbad_pkg::SRC_FIXED : cbad_pkg::SRC_WRAM;
    end else if (page == cbad_pkg::PAGE_BRAM) begin
      dec.tgt      = cbad_pkg::TGT_BRAM;
      dec.offset   = 20'(bram_idx);
      dec.bram_hit = 1'b1;
      dec.src      = command ? cbad_pkg::SRC_FIXED : cbad_pkg::SRC_BRAM;
    end else if (page == cbad_pkg::PAGE_IO) begin
      priority if (io <= cbad_pkg::IO_VDC_HI) begin
        dec.tgt    = cbad_pkg::TGT_VDC;
        dec.offset = 20'(io);
        dec.strobe = 1'b1;
      end else if (io >= cbad_pkg::IO_VCE_LO && io <= cbad_pkg::IO_VCE_HI) begin
        dec.tgt    = cbad_pkg::TGT_VCE;
        dec.offset = 20'(io[9:0]);
        dec.strobe = 1'b1;
      end else if (command && io >= cbad_pkg::IO_PSG_LO && io <= cbad_pkg::IO_PSG_HI) begin
        dec.tgt    = cbad_pkg::TGT_PSG;
        dec.offset = 20'(io[9:0]);
        dec.strobe = 1'b1;
      end else if (io == cbad_pkg::IO_TIMER_0 || io == cbad_pkg::IO_TIMER_1) begin
        dec.tgt    = cbad_pkg::TGT_TIMER;
        dec.offset = 20'(io[0]);
        dec.strobe = 1'b1;
      end else if (io == cbad_pkg::IO_PAD) begin
        dec.tgt    = cbad_pkg::TGT_PAD;
        dec.pad_wr = command;
        dec.fill   = command ? 8'h00 : pad_val;
      end else if (io == cbad_pkg::IO_IRQ_0 || io == cbad_pkg::IO_IRQ_1) begin
        dec.tgt    = cbad_pkg::TGT_IRQ;
        dec.offset = 20'(io[0]);
        dec.strobe = 1'b1;
      end else if (command && io == cbad_pkg::IO_BRAM_CTL) begin
        dec.bflag_set = 1'b1;
      end else begin
      end
    end else if (!command && bus_address <= cbad_pkg::ROM_TOP) begin
      dec.tgt    = cbad_pkg::TGT_ROM;
      dec.offset = bus_address[19:0];
      dec.strobe = 1'b1;
    end else if (!command) begin
      dec.fill = cbad_pkg::FILL_BUS;
    end else begin
    end
  end

endmodule

### src/console_bus_address_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_bus_address_decoder_top
// Bus address decoder with internal work RAM, backup RAM and joypad port.
// ----------------------------------------------------------------------------
// One bus word is accepted per cycle while the result side keeps taking
// results; each word passes through the registered read of the single-port
// RAMs (held in stage 1) and then the output register. After reset the block
// zeroes both RAMs, one entry per cycle, sweeping max(WORK_RAM_DEPTH,
// BACKUP_RAM_DEPTH) entries (32768 by default), and holds in_ready low
// meanwhile; cfg writes are taken at any time.
module console_bus_address_decoder_top #(
  parameter int WORK_RAM_DEPTH   = cbad_pkg::WORK_RAM_DEPTH_DEF,
  parameter int BACKUP_RAM_DEPTH = cbad_pkg::BACKUP_RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [20:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic [7:0]  in_pad_buttons,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic [3:0]  out_target,
  output logic [19:0] out_device_offset,
  output logic        out_external_strobe,
  output logic        out_backup_touched
);

  localparam int WA = $clog2(WORK_RAM_DEPTH);
  localparam int BA = $clog2(BACKUP_RAM_DEPTH);
  localparam int MAX_DEPTH = (WORK_RAM_DEPTH > BACKUP_RAM_DEPTH) ?
                             WORK_RAM_DEPTH : BACKUP_RAM_DEPTH;
  localparam int CA = $clog2(MAX_DEPTH);

  cbad_pkg::clr_t clr;
  logic [CA-1:0]  clr_idx;
  cbad_pkg::dec_t dec;
  logic [WA-1:0]  wram_idx;
  logic [BA-1:0]  bram_idx;

  logic tgx_r, nib_r, nib_nxt, bflag_r, bflag_nxt;
  logic accept, adv;

  logic           s1_v_r;
  cbad_pkg::dec_t s1_r;
  logic           s1_touched_r;

  logic        out_v_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_tgt_r;
  logic [19:0] out_off_r;
  logic        out_strobe_r;
  logic        out_touched_r;

  logic          wram_en, wram_we, bram_en, bram_we;
  logic [WA-1:0] wram_addr;
  logic [BA-1:0] bram_addr;
  logic [7:0]    wram_wdata, bram_wdata, wram_rdata, bram_rdata;
  logic [7:0]    rd_byte;

  cbad_clear #(
    .WORK_RAM_DEPTH  (WORK_RAM_DEPTH),
    .BACKUP_RAM_DEPTH(BACKUP_RAM_DEPTH)
  ) u_clear (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (clr),
    .clr_idx(clr_idx)
  );

  cbad_decode #(
    .WORK_RAM_DEPTH  (WORK_RAM_DEPTH),
    .BACKUP_RAM_DEPTH(BACKUP_RAM_DEPTH)
  ) u_decode (
    .command    (in_command),
    .bus_address(in_bus_address),
    .pad_buttons(in_pad_buttons),
    .nibble_sel (nib_r),
    .tgx_mode   (tgx_r),
    .dec        (dec),
    .wram_idx   (wram_idx),
    .bram_idx   (bram_idx)
  );

  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !clr.busy && (!s1_v_r || adv);
  assign accept   = in_valid && in_ready;

  assign wram_en    = clr.wram_we || (accept && dec.wram_hit);
  assign wram_we    = clr.wram_we || in_command;
  assign wram_addr  = clr.busy ? clr_idx[WA-1:0] : wram_idx;
  assign wram_wdata = clr.busy ? 8'h00 : in_write_byte;

  assign bram_en    = clr.bram_we || (accept && dec.bram_hit);
  assign bram_we    = clr.bram_we || in_command;
  assign bram_addr  = clr.busy ? clr_idx[BA-1:0] : bram_idx;
  assign bram_wdata = clr.busy ? 8'h00 : in_write_byte;

  cbad_ram #(.WIDTH(8), .DEPTH(WORK_RAM_DEPTH)) u_wram (
    .clk  (clk),
    .en   (wram_en),
    .we   (wram_we),
    .addr (wram_addr),
    .wdata(wram_wdata),
    .rdata(wram_rdata)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(BACKUP_RAM_DEPTH)) u_bram (
    .clk  (clk),
    .en   (bram_en),
    .we   (bram_we),
    .addr (bram_addr),
    .wdata(bram_wdata),
    .rdata(bram_rdata)
  );

  always_comb begin
    nib_nxt   = nib_r;
    bflag_nxt = bflag_r;
    if (accept) begin
      if (dec.pad_wr) nib_nxt = in_write_byte[0];
      if (dec.bflag_set) bflag_nxt = 1'b1;
    end
  end

  always_comb begin
    unique case (s1_r.src)
      cbad_pkg::SRC_WRAM: rd_byte = wram_rdata;
      cbad_pkg::SRC_BRAM: rd_byte = bram_rdata;
      default:            rd_byte = s1_r.fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgx_r   <= 1'b0;
      nib_r   <= 1'b0;
      bflag_r <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) tgx_r <= cfg_wdata;
      nib_r   <= nib_nxt;
      bflag_r <= bflag_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r         <= dec;
      s1_touched_r <= bflag_nxt;
    end
    if (adv) begin
      out_byte_r    <= rd_byte;
      out_tgt_r     <= s1_r.tgt;
      out_off_r     <= s1_r.offset;
      out_strobe_r  <= s1_r.strobe;
      out_touched_r <= s1_touched_r;
    end
  end

  assign out_valid           = out_v_r;
  assign out_read_byte       = out_byte_r;
  assign out_target          = out_tgt_r;
  assign out_device_offset   = out_off_r;
  assign out_external_strobe = out_strobe_r;
  assign out_backup_touched  = out_touched_r;

endmodule

### dv/bus_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_decode_checker
// Watches the bus word and result channels of the address decoder, keeps its
// own copy of work RAM, backup RAM, the joypad nibble select, the backup flag
// and the joypad mode, predicts the result of every accepted word and checks
// each accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bus_decode_checker
  import cbad_pkg::*;
#(
  parameter int WORK_RAM_DEPTH   = WORK_RAM_DEPTH_DEF,
  parameter int BACKUP_RAM_DEPTH = BACKUP_RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [20:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic [7:0]  in_pad_buttons,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_byte,
  input  logic [3:0]  out_target,
  input  logic [19:0] out_device_offset,
  input  logic        out_external_strobe,
  input  logic        out_backup_touched,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  read_byte;
    target_t     target;
    logic [19:0] offset;
    logic        strobe;
    logic        touched;
  } access_result_t;

  logic [7:0]     work_mem   [WORK_RAM_DEPTH];
  logic [7:0]     backup_mem [BACKUP_RAM_DEPTH];
  logic           nibble_sel;
  logic           touched_flag;
  logic           tgx_on;
  access_result_t results_due [$];
  access_result_t due;

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic access_result_t decode_access(input logic cmd, input logic [20:0] addr,
                                                   input logic [7:0] wb, input logic [7:0] pad);
    access_result_t r;
    logic [7:0]     page;
    logic [12:0]    io;
    logic [7:0]     inv;
    int unsigned    idx;
    r.read_byte = 8'h00;
    r.target    = TGT_NONE;
    r.offset    = 20'h0;
    r.strobe    = 1'b0;
    page        = addr[20:13];
    io          = addr[12:0];
    if (page >= PAGE_WRAM_LO && page <= PAGE_WRAM_HI) begin
      idx      = addr[14:0] % WORK_RAM_DEPTH;
      r.target = TGT_WRAM;
      r.offset = 20'(idx);
      if (cmd) work_mem[idx] = wb;
      else r.read_byte = work_mem[idx];
    end else if (page == PAGE_BRAM) begin
      idx      = addr[12:0] % BACKUP_RAM_DEPTH;
      r.target = TGT_BRAM;
      r.offset = 20'(idx);
      if (cmd) backup_mem[idx] = wb;
      else r.read_byte = backup_mem[idx];
    end else if (page == PAGE_IO) begin
      if (io <= IO_VDC_HI) begin
        r.target = TGT_VDC;
        r.offset = 20'(io);
        r.strobe = 1'b1;
      end else if (io >= IO_VCE_LO && io <= IO_VCE_HI) begin
        r.target = TGT_VCE;
        r.offset = 20'(io[9:0]);
        r.strobe = 1'b1;
      end else if (cmd && io >= IO_PSG_LO && io <= IO_PSG_HI) begin
        r.target = TGT_PSG;
        r.offset = 20'(io[9:0]);
        r.strobe = 1'b1;
      end else if (io == IO_TIMER_0 || io == IO_TIMER_1) begin
        r.target = TGT_TIMER;
        r.offset = 20'(io[0]);
        r.strobe = 1'b1;
      end else if (io == IO_PAD) begin
        r.target = TGT_PAD;
        if (cmd) begin
          nibble_sel = wb[0];
        end else begin
          inv         = ~pad;
          r.read_byte = {4'h0, nibble_sel ? inv[7:4] : inv[3:0]};
          if (tgx_on) r.read_byte = r.read_byte | PAD_TGX;
        end
      end else if (io == IO_IRQ_0 || io == IO_IRQ_1) begin
        r.target = TGT_IRQ;
        r.offset = 20'(io[0]);
        r.strobe = 1'b1;
      end else if (cmd && io == IO_BRAM_CTL) begin
        touched_flag = 1'b1;
      end
    end else if (!cmd && addr <= ROM_TOP) begin
      r.target = TGT_ROM;
      r.offset = addr[19:0];
      r.strobe = 1'b1;
    end else if (!cmd) begin
      r.read_byte = FILL_BUS;
    end
    r.touched = touched_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (work_mem[i]) work_mem[i] = 8'h00;
      foreach (backup_mem[i]) backup_mem[i] = 8'h00;
      nibble_sel   = 1'b0;
      touched_flag = 1'b0;
      tgx_on       = 1'b0;
      fail_count   = 0;
      results_due.delete();
    end else begin
      if (cfg_we) tgx_on = cfg_wdata;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, target %0d offset %h",
                                    out_target, out_device_offset));
        end else begin
          due = results_due.pop_front();
          if (out_read_byte !== due.read_byte)
            report_mismatch($sformatf("read_byte %h, expected %h", out_read_byte,
                                      due.read_byte));
          if (out_target !== due.target)
            report_mismatch($sformatf("target %0d, expected %0d", out_target, due.target));
          if (out_device_offset !== due.offset)
            report_mismatch($sformatf("device_offset %h, expected %h", out_device_offset,
                                      due.offset));
          if (out_external_strobe !== due.strobe)
            report_mismatch($sformatf("external_strobe %b, expected %b", out_external_strobe,
                                      due.strobe));
          if (out_backup_touched !== due.touched)
            report_mismatch($sformatf("backup_touched %b, expected %b", out_backup_touched,
                                      due.touched));
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(decode_access(in_command, in_bus_address, in_write_byte,
                                            in_pad_buttons));
    end
    pending <= results_due.size();
  end

endmodule

### dv/tb_console_bus_address_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_bus_address_decoder_top
// Drives bus words into the address decoder: a directed sweep of the memory
// map edges, I/O windows, joypad and backup flag in both joypad modes, then
// random phases mixing RAM, I/O, ROM and unmapped accesses with random gaps,
// output stalls and a long output hold-off. A separate checker predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_console_bus_address_decoder_top;
  import cbad_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [20:0] in_bus_address;
  logic [7:0]  in_write_byte;
  logic [7:0]  in_pad_buttons;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_byte;
  logic [3:0]  out_target;
  logic [19:0] out_device_offset;
  logic        out_external_strobe;
  logic        out_backup_touched;

  int fail_count;
  int pending;
  int cycle_count;
  int words_sent;
  int directed_words;
  int hold_req;
  bit tx_gaps;
  bit rx_gaps;

  console_bus_address_decoder_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_bus_address      (in_bus_address),
    .in_write_byte       (in_write_byte),
    .in_pad_buttons      (in_pad_buttons),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_byte       (out_read_byte),
    .out_target          (out_target),
    .out_device_offset   (out_device_offset),
    .out_external_strobe (out_external_strobe),
    .out_backup_touched  (out_backup_touched)
  );

  bus_decode_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_bus_address      (in_bus_address),
    .in_write_byte       (in_write_byte),
    .in_pad_buttons      (in_pad_buttons),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_byte       (out_read_byte),
    .out_target          (out_target),
    .out_device_offset   (out_device_offset),
    .out_external_strobe (out_external_strobe),
    .out_backup_touched  (out_backup_touched),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on each request
  initial begin : rx_side
    int seen;
    int k;
    seen = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != seen) begin
        seen = hold_req;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      if (rx_gaps && $urandom_range(0, 99) < 9) out_ready <= 1'b0;
      else out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic put_word(input logic cmd, input logic [20:0] addr, input logic [7:0] wb,
                          input logic [7:0] pad);
    if (tx_gaps) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_bus_address <= addr;
    in_write_byte  <= wb;
    in_pad_buttons <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_joypad_mode(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [12:0] pick_io();
    logic [12:0] spot;
    case ($urandom_range(0, 10))
      0:       spot = IO_VDC_HI;
      1:       spot = IO_VCE_LO;
      2:       spot = IO_VCE_HI;
      3:       spot = IO_PSG_LO;
      4:       spot = IO_PSG_HI;
      5:       spot = IO_TIMER_0;
      6:       spot = IO_TIMER_1;
      7:       spot = IO_IRQ_0;
      8:       spot = IO_IRQ_1;
      9:       spot = IO_BRAM_CTL;
      default: spot = IO_PAD;
    endcase
    case ($urandom_range(0, 5))
      0:       return 13'($urandom);
      1:       return 13'($urandom_range(0, 7));
      2, 3:    return IO_PAD;
      default: return spot + 13'($urandom_range(0, 2)) - 13'd1;
    endcase
  endfunction

  function automatic logic [20:0] pick_address();
    logic [12:0] low;
    logic [7:0]  page;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       low = 13'($urandom_range(0, 31));
      1:       low = 13'h1FE0 | 13'($urandom_range(0, 31));
      default: low = 13'($urandom);
    endcase
    if (sel < 30) begin
      page = PAGE_WRAM_LO + 8'($urandom_range(0, 3));
    end else if (sel < 45) begin
      page = PAGE_BRAM;
    end else if (sel < 70) begin
      page = PAGE_IO;
      low  = pick_io();
    end else if (sel < 85) begin
      return {1'b0, 20'($urandom)};
    end else if (sel < 93) begin
      page = 8'($urandom_range(8'h80, 8'hF6));
    end else begin
      page = 8'($urandom_range(8'hFC, 8'hFE));
    end
    return {page, low};
  endfunction

  task automatic run_random(input int count, input bit with_hold);
    int n;
    for (n = 0; n < count; n++) begin
      if (with_hold && n == count / 3) hold_req <= hold_req + 1;
      put_word(1'($urandom), pick_address(), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= 1'b0;
    in_bus_address <= 21'h0;
    in_write_byte  <= 8'h00;
    in_pad_buttons <= 8'h00;
    hold_req       <= 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    words_sent     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_joypad_mode(1'b0);

    // map edges, I/O windows, joypad nibbles, backup flag
    put_word(1'b0, 21'h000000, 8'h00, 8'h00);
    put_word(1'b0, 21'h0FFFFF, 8'h00, 8'hFF);
    put_word(1'b1, 21'h0FFFFF, 8'hFF, 8'h00);
    put_word(1'b0, 21'h100000, 8'h00, 8'h00);
    put_word(1'b1, 21'h1F0000, 8'hA5, 8'h00);
    put_word(1'b0, 21'h1F0000, 8'h00, 8'h00);
    put_word(1'b1, 21'h1F7FFF, 8'hFF, 8'h00);
    put_word(1'b0, 21'h1F7FFF, 8'h00, 8'h00);
    put_word(1'b1, 21'h1EE000, 8'h5A, 8'h00);
    put_word(1'b0, 21'h1EE000, 8'h00, 8'h00);
    put_word(1'b0, 21'h1FE003, 8'h00, 8'h00);
    put_word(1'b1, 21'h1FE405, 8'h12, 8'h00);
    put_word(1'b0, 21'h1FE406, 8'h00, 8'h00);
    put_word(1'b1, 21'h1FE809, 8'h34, 8'h00);
    put_word(1'b0, 21'h1FE800, 8'h00, 8'h00);
    put_word(1'b0, 21'h1FEC01, 8'h00, 8'h00);
    put_word(1'b1, 21'h1FF402, 8'h07, 8'h00);
    put_word(1'b0, 21'h1FF000, 8'h00, 8'h5A);
    put_word(1'b1, 21'h1FF000, 8'h01, 8'h00);
    put_word(1'b0, 21'h1FF000, 8'h00, 8'hA5);
    put_word(1'b1, 21'h1FF807, 8'h00, 8'h00);
    put_word(1'b1, 21'h1FFFFF, 8'h77, 8'h00);
    put_word(1'b0, 21'h1FC000, 8'h00, 8'h00);
    drain_results();
    write_joypad_mode(1'b1);
    put_word(1'b0, 21'h1FF000, 8'h00, 8'h00);
    put_word(1'b1, 21'h1FF000, 8'hFE, 8'h00);
    put_word(1'b0, 21'h1FF000, 8'h00, 8'hFF);
    directed_words = words_sent;
    drain_results();

    run_random(175, 1'b1);
    drain_results();
    write_joypad_mode(1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(175, 1'b0);
    drain_results();
    write_joypad_mode(1'b1);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_random(175, 1'b0);
    drain_results();
    write_joypad_mode(1'b0);
    run_random(175, 1'b1);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bus words (%0d directed) over both joypad modes.",
             words_sent, directed_words);
    $display("Traffic covered RAM, backup RAM, I/O windows, ROM and unmapped space, with stalls.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
